FILE: src/tpc_pkg.sv
// Package for the threshold product count unit.
// Holds word types, item kind codes and store sizing; no dependencies.
package tpc_pkg;

  localparam int unsigned Capacity   = 1024;
  localparam int unsigned AddrWidth  = $clog2(Capacity);
  localparam int unsigned CountWidth = 11;
  localparam int unsigned ValueWidth = 31;
  localparam int unsigned ThreshWidth = 63;
  localparam int unsigned ProdWidth  = 2 * ValueWidth;

  localparam logic [CountWidth-1:0] CountFull = CountWidth'(Capacity);

  localparam logic [1:0] KindClear = 2'd0;
  localparam logic [1:0] KindLoad  = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [ValueWidth-1:0] item_value;
  } tpc_in_t;

  typedef struct packed {
    logic [CountWidth-1:0] match_count;
    logic                  load_dropped;
  } tpc_out_t;

endpackage

FILE: src/threshold_product_count_unit.sv
// Threshold product count unit: keeps a sorted value store and counts
// stored values whose product with a query multiplier reaches a threshold.
// Depends on tpc_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one word per
//   item: clear, load or query. Output channel (out_valid_o / out_stall_i /
//   out_word_o) returns exactly one word per item. The threshold register is
//   written on the cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i); the
//   user must write it only while the unit is idle; not enforced by the block.
//   One item is worked at a time; in_stall_o is high until the result is
//   handed to the output register; the next word can be taken the cycle after.
//   Clear, unused kind and dropped loads go straight to the output push.
//   Load shifts each stored value larger than the new one up by one entry,
//   walking down from the top; the insertion walk moves one entry per
//   read-then-write pair through the store's read and write ports.
//   Query: p <= ceil(log2(n+1)) binary search probes over n stored values
//   (at most 11 probes), each a store read, a multiply, a compare.
//   At reset the store is empty, threshold is zero and no word is pending.
//   While the receiver stalls, the output word holds and one finished
//   result may wait; further work waits for the output register to free.
module threshold_product_count_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tpc_pkg::tpc_in_t                    in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tpc_pkg::tpc_out_t                   out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tpc_pkg::ThreshWidth-1:0]     cfg_data_i
);
  import tpc_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StLdRd  = 7'b0000010,
    StLdCmp = 7'b0000100,
    StQRd   = 7'b0001000,
    StQMul  = 7'b0010000,
    StQCmp  = 7'b0100000,
    StPush  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [ValueWidth-1:0]  store_q [Capacity];
  logic [ValueWidth-1:0]  rd_data_q;
  logic [AddrWidth-1:0]   rd_addr;
  logic                   wr_en;
  logic [AddrWidth-1:0]   wr_addr;
  logic [ValueWidth-1:0]  wr_data;

  logic [ThreshWidth-1:0] thresh_q;
  logic [CountWidth-1:0]  count_q, count_d;
  logic [ValueWidth-1:0]  val_q, val_d;
  logic [AddrWidth-1:0]   idx_q, idx_d;
  logic [CountWidth-1:0]  lo_q, lo_d;
  logic [CountWidth-1:0]  hi_q, hi_d;
  logic [AddrWidth-1:0]   mid_q, mid_d;
  logic [CountWidth:0]    mid_sum;
  logic [ProdWidth-1:0]   prod_q, prod_d;
  tpc_out_t               res_q, res_d;
  tpc_out_t               out_word_q, out_word_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_accept;
  logic                   out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_data_q <= store_q[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    val_d       = val_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = idx_q - AddrWidth'(1);
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = val_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          res_d = '0;
          val_d = in_word_i.item_value;
          case (in_word_i.kind)
            KindClear: begin
              count_d = '0;
              state_d = StPush;
            end
            KindLoad: begin
              if (count_q == CountFull) begin
                res_d.load_dropped = 1'b1;
                state_d = StPush;
              end else begin
                idx_d   = count_q[AddrWidth-1:0];
                count_d = count_q + CountWidth'(1);
                state_d = StLdRd;
              end
            end
            KindQuery: begin
              lo_d    = '0;
              hi_d    = count_q;
              state_d = StQRd;
            end
            default: state_d = StPush;
          endcase
        end
      end
      StLdRd: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          state_d = StPush;
        end else begin
          state_d = StLdCmp;
        end
      end
      StLdCmp: begin
        wr_en = 1'b1;
        if (rd_data_q > val_q) begin
          wr_data = rd_data_q;
          idx_d   = idx_q - AddrWidth'(1);
          state_d = StLdRd;
        end else begin
          state_d = StPush;
        end
      end
      StQRd: begin
        rd_addr = mid_sum[AddrWidth:1];
        mid_d   = mid_sum[AddrWidth:1];
        if (lo_q == hi_q) begin
          res_d.match_count = count_q - lo_q;
          state_d = StPush;
        end else begin
          state_d = StQMul;
        end
      end
      StQMul: begin
        prod_d  = {{(ProdWidth-ValueWidth){1'b0}}, val_q} *
                  {{(ProdWidth-ValueWidth){1'b0}}, rd_data_q};
        state_d = StQCmp;
      end
      StQCmp: begin
        if ({1'b0, prod_q} >= thresh_q) begin
          hi_d = {1'b0, mid_q};
        end else begin
          lo_d = {1'b0, mid_q} + CountWidth'(1);
        end
        state_d = StQRd;
      end
      StPush: begin
        if (out_free) begin
          out_word_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      thresh_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thresh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

endmodule

FILE: src/tpc_checker.sv
// Port-level checks for the threshold product count unit, bound to the top.
// Depends on tpc_pkg and threshold_product_count_unit.
module tpc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input tpc_pkg::tpc_out_t               out_word_o
);
  import tpc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.load_dropped && (out_word_o.match_count != '0)))
    else $error("count and drop flag both set");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.match_count <= CountFull))
    else $error("match count above capacity");

endmodule

bind threshold_product_count_unit tpc_checker u_tpc_checker (.*);
